// ===== hw/rtl/tlm_pkg.sv =====
// tremolo lfo modulator: shared widths, register indexes and sequencer states
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package tlm_pkg;

  // sample and phase counter widths
  localparam int SAMPLE_WIDTH = 24;
  localparam int COUNT_WIDTH  = 16;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WAVE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRY   = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WET   = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 8'd7;

  // datapath widths
  localparam int MOD_W   = 35;                 // oscillator modulation, clamped to +-2^33
  localparam int GAIN_W  = 23;                 // per-sample gain, Q.17
  localparam int WET_W   = SAMPLE_WIDTH + 6;   // wet gain times sample, rounded
  localparam int ACC_W   = SAMPLE_WIDTH + 10;  // output sum before saturation
  localparam int MUL_A_W = (SAMPLE_WIDTH + 6 > MOD_W) ? SAMPLE_WIDTH + 6 : MOD_W;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // sequencer states
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SEED  = 9'b000000010,
    S_SEEDW = 9'b000000100,
    S_OSC   = 9'b000001000,
    S_WETM  = 9'b000010000,
    S_MODM  = 9'b000100000,
    S_DRYM  = 9'b001000000,
    S_WGM   = 9'b010000000,
    S_DONE  = 9'b100000000
  } tlm_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlm_in_if.sv =====
// tremolo lfo modulator: input sample channel
// depends on tlm_pkg for the sample width
`default_nettype none

interface tlm_in_if;
  import tlm_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tlm_out_if.sv =====
// tremolo lfo modulator: result sample channel
// depends on tlm_pkg for the sample width
`default_nettype none

interface tlm_out_if;
  import tlm_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tlm_cfg_if.sv =====
// tremolo lfo modulator: configuration write channel
// depends on tlm_pkg for index and data widths
`default_nettype none

interface tlm_cfg_if;
  import tlm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tremolo_lfo_modulator_unit.sv =====
// Tremolo amplitude modulator: one signed sample word in, one modulated sample word out.
// Channels: in_if (sample_in), out_if (sample_out), both valid/ready; cfg_if writes
// register <index> with <data> (0 waveform, 1 half cycle, 2 coef, 3 seed, 4 tri step,
// 5 dry gain, 6 wet gain, 7 depth; higher indexes are dropped). cfg_if.ready is always
// high; writes to registers 0 to 4 restart the oscillator phase.
// Timing: one 68-bit product multiplier is shared by every product of a sample and a
// small one-hot sequencer steps through them, one product per cycle. A word accepted
// in idle passes through the oscillator, wet, modulation, dry and wet-gain steps and
// a final step; its result shows on out_if in the same cycle that in_if is ready again,
// so a new word is taken only after the last one is through. The first sine sample
// after reset, after a restart or after the end of a half cycle first reloads the
// oscillator from its seed, which costs one multiply and one write-back step.
// in_if is ready only while the sequencer is idle. The result sits in an output
// register; a new word is still taken while it waits, and the sequencer holds its
// last step until out_if takes the earlier result.
// Reset (synchronous, rst_n low) loads the register defaults, restarts the phase and
// empties the output register; no clearing pass follows.
`default_nettype none

module tremolo_lfo_modulator_unit (
  input  logic                clk,
  input  logic                rst_n,
  tlm_in_if.sink              in_if,
  tlm_out_if.source           out_if,
  tlm_cfg_if.sink             cfg_if
);
  import tlm_pkg::*;

  localparam logic signed [MOD_W-1:0] MOD_ONE = MOD_W'(64'sd1 <<< 30);
  localparam logic signed [MOD_W-1:0] MOD_MAX = MOD_W'(64'sd1 <<< 33);
  localparam logic signed [PROD_W-1:0] RND15 = PROD_W'(64'sd1 <<< 15);
  localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(64'sd1 <<< 16);
  localparam logic signed [PROD_W-1:0] RND29 = PROD_W'(64'sd1 <<< 29);

  // configuration registers
  logic                   cfg_wave_r;
  logic [15:0]            cfg_half_r;
  logic signed [31:0]     cfg_coef_r;
  logic signed [30:0]     cfg_seed_r;
  logic [24:0]            cfg_step_r;
  logic [19:0]            cfg_dry_r;
  logic [19:0]            cfg_wet_r;
  logic [16:0]            cfg_depth_r;

  // oscillator state
  logic signed [31:0]     osc_prev_r;
  logic signed [31:0]     osc_cur_r;
  logic [COUNT_WIDTH-1:0] tri_count_r;
  logic [COUNT_WIDTH-1:0] half_count_r;
  logic                   first_half_r;
  logic                   reseed_r;

  // sequencer and datapath registers
  tlm_state_t                 state_r;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [MOD_W-1:0]    mod_r;
  logic signed [GAIN_W-1:0]   gain_r;
  logic signed [WET_W-1:0]    wet_part_r;
  logic signed [WET_W-1:0]    dry_part_r;
  logic                       fh_used_r;
  logic                       half_end_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_data_r;

  logic                       sine;
  logic                       in_acc;
  logic                       cfg_acc;
  logic                       out_free;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic                       mul_en;

  logic signed [PROD_W-1:0]   p_rnd30;
  logic signed [PROD_W-1:0]   p_seed_wide;
  logic signed [PROD_W-1:0]   p_y_wide;
  logic signed [31:0]         seed_prev;
  logic signed [31:0]         y_sat;
  logic signed [MOD_W-1:0]    mod_nxt;
  logic signed [PROD_W-1:0]   p_flr30;
  logic signed [PROD_W-1:0]   p_rnd16;
  logic signed [PROD_W-1:0]   p_rnd17;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SAMPLE_WIDTH-1:0] acc_sat;

  logic [16:0]                depth_d;
  logic [17:0]                multi;
  logic [17:0]                shift;

  logic [COUNT_WIDTH-1:0]     hc_inc;
  logic                       half_end;

  assign sine     = (cfg_wave_r == 1'b0);
  assign in_acc   = in_if.valid && in_if.ready;
  assign cfg_acc  = cfg_if.valid && cfg_if.ready;
  assign out_free = !out_valid_r || out_if.ready;

  assign in_if.ready       = (state_r == S_IDLE);
  assign cfg_if.ready      = 1'b1;
  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_data_r;

  // depth to multi and shift, Q.17
  always_comb begin
    depth_d = (cfg_depth_r > 17'd65536) ? 17'd65536 : cfg_depth_r;
    if (sine) begin
      multi = 18'd65536 - 18'(depth_d);
      shift = 18'd65536 + 18'(depth_d);
    end else begin
      multi = 18'((18'd65536 - 18'(depth_d)) << 1);
      shift = 18'(18'(depth_d) << 1);
    end
  end

  // half cycle end detect
  assign hc_inc   = half_count_r + 1'b1;
  assign half_end = (hc_inc == COUNT_WIDTH'(cfg_half_r));

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    case (state_r)
      S_SEED: begin
        mul_a  = MUL_A_W'(cfg_seed_r);
        mul_b  = MUL_B_W'(cfg_coef_r);
        mul_en = 1'b1;
      end
      S_OSC: begin
        if (sine) begin
          mul_a = MUL_A_W'(osc_cur_r);
          mul_b = MUL_B_W'(cfg_coef_r);
        end else begin
          mul_a = MUL_A_W'(tri_count_r);
          mul_b = MUL_B_W'(cfg_step_r);
        end
        mul_en = 1'b1;
      end
      S_WETM: begin
        mul_a  = MUL_A_W'(cfg_wet_r);
        mul_b  = MUL_B_W'(x_r);
        mul_en = 1'b1;
      end
      S_MODM: begin
        mul_a  = MUL_A_W'(mod_r);
        mul_b  = MUL_B_W'(multi);
        mul_en = 1'b1;
      end
      S_DRYM: begin
        mul_a  = MUL_A_W'(cfg_dry_r);
        mul_b  = MUL_B_W'(x_r);
        mul_en = 1'b1;
      end
      S_WGM: begin
        mul_a  = MUL_A_W'(wet_part_r);
        mul_b  = MUL_B_W'(gain_r);
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // post-product rounding, oscillator and saturation logic
  always_comb begin
    p_rnd30     = (prod_r + RND29) >>> 30;
    p_seed_wide = p_rnd30;
    p_y_wide    = p_rnd30 - PROD_W'(osc_prev_r);

    // saturate to 32-bit signed
    if (&p_seed_wide[PROD_W-1:31] || ~|p_seed_wide[PROD_W-1:31]) begin
      seed_prev = p_seed_wide[31:0];
    end else begin
      seed_prev = p_seed_wide[PROD_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    if (&p_y_wide[PROD_W-1:31] || ~|p_y_wide[PROD_W-1:31]) begin
      y_sat = p_y_wide[31:0];
    end else begin
      y_sat = p_y_wide[PROD_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end

    // modulation value, Q5.30; a triangle product of 2^27 or more clamps to 2^33
    if (sine) begin
      mod_nxt = fh_used_r ? MOD_ONE + MOD_W'(y_sat) : MOD_ONE - MOD_W'(y_sat);
    end else if (|prod_r[PROD_W-1:27]) begin
      mod_nxt = MOD_MAX;
    end else begin
      mod_nxt = MOD_W'({prod_r[26:0], 6'b000000});
    end

    p_flr30 = prod_r >>> 30;
    p_rnd16 = (prod_r + RND15) >>> 16;
    p_rnd17 = (prod_r + RND16) >>> 17;

    // final sum and output saturation
    acc = ACC_W'(dry_part_r) + ACC_W'(p_rnd17);
    if (&acc[ACC_W-1:SAMPLE_WIDTH-1] || ~|acc[ACC_W-1:SAMPLE_WIDTH-1]) begin
      acc_sat = acc[SAMPLE_WIDTH-1:0];
    end else begin
      acc_sat = acc[ACC_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                             : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  // shared multiplier product register
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_if.sample_in;
    end
    case (state_r)
      S_WETM:  mod_r      <= mod_nxt;
      S_MODM:  wet_part_r <= WET_W'(p_rnd16);
      S_DRYM:  gain_r     <= GAIN_W'(p_flr30) + GAIN_W'(shift);
      S_WGM:   dry_part_r <= WET_W'(p_rnd16);
      default: begin
      end
    endcase
    if (state_r == S_OSC) begin
      fh_used_r  <= first_half_r;
      half_end_r <= half_end;
    end
  end

  // sine oscillator samples
  always_ff @(posedge clk) begin
    if (state_r == S_SEEDW) begin
      osc_prev_r <= seed_prev;
      osc_cur_r  <= 32'(cfg_seed_r);
    end else if (state_r == S_WETM && sine) begin
      osc_prev_r <= osc_cur_r;
      osc_cur_r  <= y_sat;
    end
  end

  // sequencer and phase counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tri_count_r  <= '0;
      half_count_r <= '0;
      first_half_r <= 1'b1;
      reseed_r     <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      // result valid: raised by the final step, dropped once taken
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= (sine && reseed_r) ? S_SEED : S_OSC;
          end
        end
        S_SEED: state_r <= S_SEEDW;
        S_SEEDW: begin
          reseed_r <= 1'b0;
          state_r  <= S_OSC;
        end
        S_OSC: begin
          if (!sine) begin
            tri_count_r <= first_half_r ? tri_count_r + 1'b1 : tri_count_r - 1'b1;
          end
          half_count_r <= half_end ? '0 : hc_inc;
          if (half_end) begin
            first_half_r <= !first_half_r;
          end
          state_r <= S_WETM;
        end
        S_WETM: begin
          if (sine && half_end_r) begin
            reseed_r <= 1'b1;
          end
          state_r <= S_MODM;
        end
        S_MODM: state_r <= S_DRYM;
        S_DRYM: state_r <= S_WGM;
        S_WGM:  state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // phase restart on oscillator register writes
      if (cfg_acc && cfg_if.index <= REG_STEP) begin
        tri_count_r  <= '0;
        half_count_r <= '0;
        first_half_r <= 1'b1;
        reseed_r     <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_data_r <= acc_sat;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_wave_r  <= 1'b0;
      cfg_half_r  <= 16'd1000;
      cfg_coef_r  <= 32'sh7FFF_FFFF;
      cfg_seed_r  <= '0;
      cfg_step_r  <= 25'd16777;
      cfg_dry_r   <= 20'd65536;
      cfg_wet_r   <= 20'd65536;
      cfg_depth_r <= 17'd32768;
    end else if (cfg_acc) begin
      case (cfg_if.index)
        REG_WAVE:  cfg_wave_r  <= cfg_if.data[0];
        REG_HALF:  cfg_half_r  <= cfg_if.data[15:0];
        REG_COEF:  cfg_coef_r  <= cfg_if.data[31:0];
        REG_SEED:  cfg_seed_r  <= cfg_if.data[30:0];
        REG_STEP:  cfg_step_r  <= cfg_if.data[24:0];
        REG_DRY:   cfg_dry_r   <= cfg_if.data[19:0];
        REG_WET:   cfg_wet_r   <= cfg_if.data[19:0];
        REG_DEPTH: cfg_depth_r <= cfg_if.data[16:0];
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  // a taken word keeps the input closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_if.ready)
    else $error("input taken again right after an accept");

  // a result only appears after the last sequencer step
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word raised outside the final step");

  // the sine step never runs on an oscillator that still needs its seed
  a_seeded_before_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OSC && sine) |-> !reseed_r)
    else $error("sine step with stale oscillator state");

  // the final step does not overwrite a result that was not taken
  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result lost");
`endif

endmodule

`default_nettype wire

// ===== sim/tremolo_lfo_modulator_unit_tb.sv =====
// testbench for tremolo_lfo_modulator_unit: a directed table, then random phases of
// register settings and sample words, checked against the table's words or an in-bench gain predictor
// depends on tlm_pkg, tlm_in_if, tlm_out_if, tlm_cfg_if and the rtl top level
`timescale 1ns / 1ps

module tremolo_lfo_modulator_unit_tb;
  import tlm_pkg::*;

  localparam int     QUIET_LIMIT = 1000;
  localparam int     RAND_ITEMS  = 1900;
  localparam int     CALM_TAIL   = 250;
  localparam real    PI          = 3.14159265358979;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint MOD_LIM     = 64'sd8589934592;
  localparam longint I32_MAX     = 64'sd2147483647;
  localparam longint I32_MIN     = -64'sd2147483648;
  localparam longint SAT_HI      = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint SAT_LO      = -(64'sd1 <<< (SAMPLE_WIDTH - 1));

  // indexes past the register map, dropped by the block
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

  typedef enum bit [1:0] {ROW_CFG, ROW_SAMPLE, ROW_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [CFG_IDX_W-1:0]           idx;
    logic [CFG_DATA_W-1:0]          data;
    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic signed [SAMPLE_WIDTH-1:0] want;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tlm_in_if  in_if ();
  tlm_out_if out_if ();
  tlm_cfg_if cfg_if ();

  tremolo_lfo_modulator_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #4 clk = ~clk;

  // directed table: defaults, gain extremes, a short triangle, ignored writes,
  // depth saturation, then an extreme sine setting with a zero half cycle
  dir_row_t dir_rows [44] = '{
    '{ROW_KNOWN,  '0,        '0,            24'sd0,       24'sd0},
    '{ROW_KNOWN,  '0,        '0,            24'sd1000,    24'sd2000},
    '{ROW_KNOWN,  '0,        '0,            -24'sd1,      -24'sd2},
    '{ROW_KNOWN,  '0,        '0,            24'sd4194304, 24'sh7FFFFF},
    '{ROW_KNOWN,  '0,        '0,            24'sh800000,  24'sh800000},
    '{ROW_KNOWN,  '0,        '0,            24'sh7FFFFF,  24'sh7FFFFF},
    '{ROW_CFG,    REG_DRY,   32'd0,         24'sd0,       24'sd0},
    '{ROW_CFG,    REG_WET,   32'd0,         24'sd0,       24'sd0},
    '{ROW_KNOWN,  '0,        '0,            24'sh800000,  24'sd0},
    '{ROW_KNOWN,  '0,        '0,            24'sh7FFFFF,  24'sd0},
    '{ROW_CFG,    REG_DRY,   32'h000F_FFFF, 24'sd0,       24'sd0},
    '{ROW_KNOWN,  '0,        '0,            24'sh7FFFFF,  24'sh7FFFFF},
    '{ROW_KNOWN,  '0,        '0,            24'sh800000,  24'sh800000},
    '{ROW_CFG,    REG_WET,   32'd65536,     24'sd0,       24'sd0},
    '{ROW_CFG,    REG_DRY,   32'd0,         24'sd0,       24'sd0},
    '{ROW_CFG,    REG_DEPTH, 32'd0,         24'sd0,       24'sd0},
    '{ROW_CFG,    REG_STEP,  32'h0100_0000, 24'sd0,       24'sd0},
    '{ROW_CFG,    REG_HALF,  32'd4,         24'sd0,       24'sd0},
    '{ROW_CFG,    REG_WAVE,  32'd1,         24'sd0,       24'sd0},
    '{ROW_KNOWN,  '0,        '0,            24'sd1000,    24'sd0},
    '{ROW_KNOWN,  '0,        '0,            24'sd1000,    24'sd1000},
    '{ROW_KNOWN,  '0,        '0,            24'sd1000,    24'sd2000},
    '{ROW_KNOWN,  '0,        '0,            24'sd1000,    24'sd3000},
    '{ROW_KNOWN,  '0,        '0,            24'sd1000,    24'sd4000},
    '{ROW_KNOWN,  '0,        '0,            24'sd1000,    24'sd3000},
    '{ROW_KNOWN,  '0,        '0,            24'sd1000,    24'sd2000},
    '{ROW_KNOWN,  '0,        '0,            24'sd1000,    24'sd1000},
    '{ROW_KNOWN,  '0,        '0,            24'sd1000,    24'sd0},
    '{ROW_CFG,    REG_UNUSED_LO, 32'hFFFF_FFFF, 24'sd0,   24'sd0},
    '{ROW_CFG,    REG_UNUSED_HI, 32'd0,     24'sd0,       24'sd0},
    '{ROW_CFG,    REG_DEPTH, 32'h0001_FFFF, 24'sd0,       24'sd0},
    '{ROW_KNOWN,  '0,        '0,            -24'sd5000,   -24'sd5000},
    '{ROW_CFG,    REG_WAVE,  32'd0,         24'sd0,       24'sd0},
    '{ROW_CFG,    REG_COEF,  32'h8000_0000, 24'sd0,       24'sd0},
    '{ROW_CFG,    REG_SEED,  32'h3FFF_FFFF, 24'sd0,       24'sd0},
    '{ROW_CFG,    REG_HALF,  32'd0,         24'sd0,       24'sd0},
    '{ROW_CFG,    REG_DEPTH, 32'd0,         24'sd0,       24'sd0},
    '{ROW_CFG,    REG_WET,   32'h000F_FFFF, 24'sd0,       24'sd0},
    '{ROW_CFG,    REG_DRY,   32'd65536,     24'sd0,       24'sd0},
    '{ROW_SAMPLE, '0,        '0,            24'sh7FFFFF,  24'sd0},
    '{ROW_SAMPLE, '0,        '0,            24'sh800000,  24'sd0},
    '{ROW_SAMPLE, '0,        '0,            24'sd1,       24'sd0},
    '{ROW_SAMPLE, '0,        '0,            24'sd0,       24'sd0},
    '{ROW_SAMPLE, '0,        '0,            -24'sd1234567, 24'sd0}
  };

  // register copy and oscillator state of the gain predictor
  bit                      wave_sel;
  logic [15:0]             half_len;
  logic signed [31:0]      coef_q30;
  logic signed [30:0]      seed_q30;
  logic [24:0]             tri_step;
  logic [19:0]             dry_gain;
  logic [19:0]             wet_gain;
  logic [16:0]             depth_lvl;
  longint                  lfo_prev;
  longint                  lfo_cur;
  logic [COUNT_WIDTH-1:0]  tri_cnt;
  logic [COUNT_WIDTH-1:0]  half_cnt;
  bit                      rising_half;

  logic signed [SAMPLE_WIDTH-1:0] sample_out_q [$];
  int n_fail     = 0;
  int n_rand     = 0;
  int stall_left = 0;
  int quiet      = 0;
  bit in_gaps    = 1'b1;
  bit out_stalls = 1'b1;

  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void lfo_reseed();
    lfo_cur  = longint'(seed_q30);
    lfo_prev = clip(round_shift(longint'(coef_q30) * longint'(seed_q30), 30),
                    I32_MIN, I32_MAX);
  endfunction

  function automatic void phase_restart();
    lfo_reseed();
    tri_cnt     = '0;
    half_cnt    = '0;
    rising_half = 1'b1;
  endfunction

  function automatic void load_defaults();
    wave_sel  = 1'b0;
    half_len  = 16'd1000;
    coef_q30  = 32'sh7FFF_FFFF;
    seed_q30  = '0;
    tri_step  = 25'd16777;
    dry_gain  = 20'd65536;
    wet_gain  = 20'd65536;
    depth_lvl = 17'd32768;
    phase_restart();
  endfunction

  // register write as the block sees it; waveform and oscillator writes restart the phase
  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_WAVE:  wave_sel  = data[0];
      REG_HALF:  half_len  = data[15:0];
      REG_COEF:  coef_q30  = data;
      REG_SEED:  seed_q30  = data[30:0];
      REG_STEP:  tri_step  = data[24:0];
      REG_DRY:   dry_gain  = data[19:0];
      REG_WET:   wet_gain  = data[19:0];
      REG_DEPTH: depth_lvl = data[16:0];
      default: ;
    endcase
    if (idx <= REG_STEP) phase_restart();
  endfunction

  // one sample through the lfo gain path; advances the oscillator state
  function automatic logic signed [SAMPLE_WIDTH-1:0] tremolo_sample(
      input logic signed [SAMPLE_WIDTH-1:0] x);
    longint xv, y, modv, d, multi, shift, g, acc;
    xv = longint'(x);
    if (!wave_sel) begin
      y = clip(round_shift(longint'(coef_q30) * lfo_cur, 30) - lfo_prev, I32_MIN, I32_MAX);
      lfo_prev = lfo_cur;
      lfo_cur  = y;
      modv = rising_half ? ONE_Q30 + y : ONE_Q30 - y;
    end else begin
      modv = longint'(tri_cnt) * longint'(tri_step) * 64;
      tri_cnt = rising_half ? tri_cnt + 1'b1 : tri_cnt - 1'b1;
    end
    modv = clip(modv, -MOD_LIM, MOD_LIM);

    // half cycle end
    half_cnt = half_cnt + 1'b1;
    if (half_cnt == half_len[COUNT_WIDTH-1:0]) begin
      half_cnt    = '0;
      rising_half = !rising_half;
      if (!wave_sel) lfo_reseed();
    end

    d = (depth_lvl > 17'd65536) ? 64'sd65536 : longint'(depth_lvl);
    if (!wave_sel) begin
      multi = 64'sd65536 - d;
      shift = multi + 2 * d;
    end else begin
      multi = 2 * (64'sd65536 - d);
      shift = 2 * d;
    end
    g = ((modv * multi) >>> 30) + shift;

    acc = round_shift(longint'(dry_gain) * xv, 16)
        + round_shift(round_shift(longint'(wet_gain) * xv, 16) * g, 17);
    acc = clip(acc, SAT_LO, SAT_HI);
    return acc[SAMPLE_WIDTH-1:0];
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    logic signed [SAMPLE_WIDTH-1:0] v;
    v = SAMPLE_WIDTH'($urandom);
    case ($urandom_range(0, 7))
      0: v = v >>> $urandom_range(8, 22);
      1: v = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      2: v = v >>> $urandom_range(1, 7);
      default: ;
    endcase
    return v;
  endfunction

  // send one sample word, with an optional idle burst first
  task automatic feed_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input bit known,
                             input logic signed [SAMPLE_WIDTH-1:0] want);
    logic signed [SAMPLE_WIDTH-1:0] predicted;
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= s;
    do @(posedge clk); while (!in_if.ready);
    predicted = tremolo_sample(s);
    sample_out_q.push_back(known ? want : predicted);
  endtask

  // stop sending and wait until every result is back and the sequencer is idle
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sample_out_q.size() != 0 || !in_if.ready) @(posedge clk);
  endtask

  // register write; valid stays high for back-to-back writes
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    apply_cfg(idx, data);
  endtask

  // new random setting: a full oscillator setup plus gains and depth, or gains and depth alone
  task automatic random_config();
    logic [31:0] noise;
    logic [15:0] half;
    logic [31:0] coef_w;
    logic [31:0] seed_w;
    logic [24:0] step_w;
    longint      c;
    longint      s;
    int          n_half;
    bit          sine;
    real         w;
    if ($urandom_range(0, 3) != 0) begin
      sine = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0:       half = 16'd0;
        1:       half = 16'hFFFF;
        2, 3:    half = 16'($urandom_range(41, 1500));
        4:       half = 16'd1;
        default: half = 16'($urandom_range(2, 40));
      endcase
      n_half = (half == 0) ? 65536 : int'(half);
      if ($urandom_range(0, 3) != 0) begin
        w = PI / real'(n_half);
        c = longint'(2.0 * $cos(w) * 1073741824.0);
        s = longint'(-$sin(w) * 1073741824.0);
        c = clip(c, I32_MIN, I32_MAX);
        coef_w = c[31:0];
        seed_w = s[31:0];
      end else begin
        coef_w = $urandom;
        seed_w = $urandom;
      end
      case ($urandom_range(0, 5))
        0:       step_w = 25'h100_0000;
        1:       step_w = 25'($urandom);
        default: step_w = 25'(16777216 / n_half);
      endcase
      noise = $urandom;
      cfg_write(REG_WAVE, {noise[31:1], sine});
      noise = $urandom;
      cfg_write(REG_HALF, {noise[31:16], half});
      cfg_write(REG_COEF, coef_w);
      noise = $urandom;
      cfg_write(REG_SEED, {noise[31], seed_w[30:0]});
      noise = $urandom;
      cfg_write(REG_STEP, {noise[31:25], step_w});
    end

    // gains and depth, mostly near unity so outputs do not always saturate
    noise = $urandom;
    case ($urandom_range(0, 7))
      0:       noise[19:0] = '0;
      1:       noise[19:0] = 20'hFFFFF;
      2:       ;
      default: noise[19:0] = 20'($urandom_range(0, 98304));
    endcase
    cfg_write(REG_DRY, noise);
    noise = $urandom;
    case ($urandom_range(0, 7))
      0:       noise[19:0] = '0;
      1:       noise[19:0] = 20'hFFFFF;
      2:       ;
      default: noise[19:0] = 20'($urandom_range(0, 98304));
    endcase
    cfg_write(REG_WET, noise);
    noise = $urandom;
    case ($urandom_range(0, 7))
      0:       noise[16:0] = '0;
      1:       noise[16:0] = 17'd65536;
      2:       ;
      default: noise[16:0] = 17'($urandom_range(0, 65536));
    endcase
    cfg_write(REG_DEPTH, noise);

    if ($urandom_range(0, 5) == 0)
      cfg_write(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
  endtask

  // result side: check each word against the oldest expected word, stall in bursts
  always @(posedge clk) begin : out_side
    logic signed [SAMPLE_WIDTH-1:0] want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (sample_out_q.size() == 0) begin
          $error("sample_out: word %0d with no sample pending", out_if.sample_out);
          n_fail++;
        end else begin
          want = sample_out_q.pop_front();
          if (out_if.sample_out !== want) begin
            $error("sample_out: expected %0d, got %0d", want, out_if.sample_out);
            n_fail++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (out_stalls && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("** tremolo_lfo_modulator_unit: FAILED **");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    bit cfg_open;
    int n;
    bit calm;
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    load_defaults();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    cfg_open = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        cfg_write(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        if (cfg_open) begin
          cfg_if.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        feed_sample(dir_rows[i].smp, dir_rows[i].kind == ROW_KNOWN, dir_rows[i].want);
      end
    end

    // random phases, no idling in the tail
    while (n_rand < RAND_ITEMS) begin
      settle();
      calm       = (n_rand >= RAND_ITEMS - CALM_TAIL);
      in_gaps    = !calm && ($urandom_range(0, 3) != 0);
      out_stalls = !calm && ($urandom_range(0, 3) != 0);
      random_config();
      cfg_if.valid <= 1'b0;
      n = $urandom_range(10, 90);
      repeat (n) begin
        feed_sample(rand_sample(), 1'b0, '0);
        n_rand++;
      end
    end

    in_if.valid <= 1'b0;
    while (sample_out_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_fail == 0)
      $display("** tremolo_lfo_modulator_unit: PASSED **");
    else
      $display("** tremolo_lfo_modulator_unit: FAILED **");
    $finish;
  end

endmodule
